FILE: rtl/core/ddpu_pkg.sv
// Package with shared types, constants and the arctangent table for the pose update core.
`default_nettype none
package ddpu_pkg;

	localparam int AngW = 40;
	localparam int VecW = 36;

	localparam logic signed [AngW-1:0] AngPi     = 40'sd3373259426;
	localparam logic signed [AngW-1:0] AngHalfPi = 40'sd1686629713;
	localparam logic signed [AngW-1:0] AngTwoPi  = 40'sd6746518852;
	// Reciprocal of a full turn scaled by 2^46, used on the angle bits above bit 21.
	localparam logic [13:0]            RecipTwoPi = 14'd10430;
	localparam logic signed [31:0]     CordicKinv = 32'sd652032874;
	localparam logic [15:0]            IwbReset  = 16'd3277;
	localparam logic signed [31:0]     PosXReset = -32'sd4587520;
	localparam logic signed [31:0]     PosZReset = -32'sd3932160;
	localparam logic signed [15:0]     DirXReset = 16'sd0;
	localparam logic signed [15:0]     DirZReset = 16'sd16384;
	localparam logic signed [15:0]     AngClamp  = 16'sd25736;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_REDUCE, ST_QUOT, ST_REM, ST_FOLD, ST_SCALE, ST_ROT,
		ST_ROTEND, ST_POSMUL, ST_POSADD, ST_ATINIT, ST_ATAN, ST_DONE
	} ddpu_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic reduce;
		logic quot;
		logic remainder;
		logic fold;
		logic scale;
		logic rot_step;
		logic rot_end;
		logic pos_mul;
		logic pos_add;
		logic at_init;
		logic at_step;
		logic finish;
		logic iter_clr;
	} ddpu_cmd_t;

	typedef struct packed {
		logic iter_last;
	} ddpu_sts_t;

	function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
		case (i)
			5'd0: return 40'sd843314856;
			5'd1: return 40'sd497837829;
			5'd2: return 40'sd263043836;
			5'd3: return 40'sd133525158;
			5'd4: return 40'sd67021686;
			5'd5: return 40'sd33543515;
			5'd6: return 40'sd16775850;
			5'd7: return 40'sd8388437;
			5'd8: return 40'sd4194282;
			5'd9: return 40'sd2097149;
			5'd10: return 40'sd1048575;
			5'd11: return 40'sd524287;
			5'd12: return 40'sd262143;
			5'd13: return 40'sd131071;
			5'd14: return 40'sd65535;
			5'd15: return 40'sd32767;
			5'd16: return 40'sd16383;
			5'd17: return 40'sd8191;
			5'd18: return 40'sd4095;
			5'd19: return 40'sd2047;
			5'd20: return 40'sd1023;
			5'd21: return 40'sd511;
			5'd22: return 40'sd255;
			5'd23: return 40'sd127;
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ddpu_if.sv
// Valid/ready channel interfaces for the wheel speed input and the pose output.
`default_nettype none
interface ddpu_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_speed;
	logic signed [15:0] right_speed;
	modport source (output valid, left_speed, right_speed, input ready);
	modport sink (input valid, left_speed, right_speed, output ready);
endinterface

interface ddpu_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_x;
	logic signed [31:0] position_z;
	logic signed [15:0] heading_x;
	logic signed [15:0] heading_z;
	logic signed [15:0] heading_angle;
	modport source (output valid, position_x, position_z, heading_x, heading_z,
		heading_angle, input ready);
	modport sink (input valid, position_x, position_z, heading_x, heading_z,
		heading_angle, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ddpu_ctrl.sv
// Controller state machine sequencing the two rotations, the position update and the atan2.
`default_nettype none
module ddpu_ctrl
	import ddpu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire ddpu_sts_t sts,
	output ddpu_cmd_t      cmd
);

	ddpu_state_t state_q, state_d;
	logic        pass_q, pass_d;
	logic        ovalid_q, ovalid_d;

	// State, pass and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pass_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pass_q   <= pass_d;
			ovalid_q <= ovalid_d;
		end
	end

	assign out_valid = ovalid_q;

	// Next state and commands. Pass 0 rotates by the full angle, pass 1 by half.
	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		ovalid_d = ovalid_q && !out_ready;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !ovalid_q || out_ready;
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					pass_d   = 1'b0;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_REDUCE;
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				state_d    = ST_QUOT;
			end
			ST_QUOT: begin
				cmd.quot = 1'b1;
				state_d  = ST_REM;
			end
			ST_REM: begin
				cmd.remainder = 1'b1;
				state_d       = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale    = 1'b1;
				cmd.iter_clr = 1'b1;
				state_d      = ST_ROT;
			end
			ST_ROT: begin
				cmd.rot_step = 1'b1;
				if (sts.iter_last) state_d = ST_ROTEND;
			end
			ST_ROTEND: begin
				cmd.rot_end = 1'b1;
				if (pass_q) begin
					state_d = ST_POSMUL;
				end else begin
					pass_d  = 1'b1;
					state_d = ST_PREP;
				end
			end
			ST_POSMUL: begin
				cmd.pos_mul = 1'b1;
				state_d     = ST_POSADD;
			end
			ST_POSADD: begin
				cmd.pos_add = 1'b1;
				state_d     = ST_ATINIT;
			end
			ST_ATINIT: begin
				cmd.at_init  = 1'b1;
				cmd.iter_clr = 1'b1;
				state_d      = ST_ATAN;
			end
			ST_ATAN: begin
				cmd.at_step = 1'b1;
				if (sts.iter_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				ovalid_d   = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/ddpu_dp.sv
// Datapath: angle product, shared CORDIC unit, position multiply-add and result registers.
`default_nettype none
module ddpu_dp
	import ddpu_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_data,
	input  wire logic signed [15:0] left_speed,
	input  wire logic signed [15:0] right_speed,
	input  wire ddpu_cmd_t          cmd,
	output ddpu_sts_t               sts,
	output logic signed [31:0]      position_x,
	output logic signed [31:0]      position_z,
	output logic signed [15:0]      heading_x,
	output logic signed [15:0]      heading_z,
	output logic signed [15:0]      heading_angle
);

	localparam int ItW = $clog2(CORDIC_ITERATIONS);

	logic [15:0]            iwb_q;
	logic signed [31:0]     pos_x_q, pos_z_q;
	logic signed [15:0]     dir_x_q, dir_z_q;
	logic signed [15:0]     new_x_q, new_z_q, mid_x_q, mid_z_q;
	logic signed [16:0]     diff_q;
	logic signed [16:0]     sum_q;
	logic signed [33:0]     prod_q;
	logic                   pass_q;
	logic signed [AngW-1:0] mag_q;
	logic                   neg_q;
	logic [5:0]             quo_q;
	logic signed [AngW-1:0] ang_q;
	logic signed [VecW-1:0] x_q, z_q;
	logic signed [AngW-1:0] acc_q;
	logic [ItW-1:0]         it_q;
	logic signed [33:0]     stepx_q, stepz_q;
	logic signed [15:0]     angle_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) iwb_q <= IwbReset;
		else if (cfg_we) iwb_q <= cfg_data;
	end

	// Pose state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= PosXReset;
			pos_z_q <= PosZReset;
			dir_x_q <= DirXReset;
			dir_z_q <= DirZReset;
		end else if (cmd.pos_add) begin
			pos_x_q <= pos_x_q + 32'(stepx_q);
			pos_z_q <= pos_z_q + 32'(stepz_q);
			dir_x_q <= new_x_q;
			dir_z_q <= new_z_q;
		end
	end

	assign sts.iter_last = (32'(it_q) == CORDIC_ITERATIONS - 1);

	// Combinational helpers for the CORDIC step and reductions.
	logic signed [AngW-1:0] tab;
	logic signed [VecW-1:0] sh_x, sh_z;
	logic signed [AngW-1:0] pmag;
	logic [29:0]            quo_prod;
	logic signed [AngW-1:0] rem;
	logic signed [AngW-1:0] red;
	logic signed [VecW+31:0] px, pz;
	logic signed [VecW-1:0]  rx, rz;
	logic signed [15:0]      sx, sz;
	logic signed [AngW-1:0]  ar;

	always_comb begin
		tab  = atan_entry(5'(it_q));
		sh_x = x_q >>> it_q;
		sh_z = z_q >>> it_q;
		// Magnitude of the angle product; the angle is this times 64 or 32.
		pmag = (prod_q < 0) ? -AngW'(prod_q) : AngW'(prod_q);
		// The angle magnitude stays below 2^38, so its top bits estimate the turn count.
		// The estimate is exact or one short.
		quo_prod = mag_q[37:22] * RecipTwoPi;
		// Remainder after whole turns, with one correction step.
		rem = mag_q - $signed(AngW'(quo_q)) * AngTwoPi;
		if (rem >= AngTwoPi) rem = rem - AngTwoPi;
		// Bring the reduced angle into [-pi, pi].
		red = ang_q;
		if (red > AngPi) red = red - AngTwoPi;
		else if (red < -AngPi) red = red + AngTwoPi;
		px = x_q * CordicKinv;
		pz = z_q * CordicKinv;
		rx = x_q + 36'sd32768;
		rz = z_q + 36'sd32768;
		rx = rx >>> 16;
		rz = rz >>> 16;
		sx = (rx > 36'sd32767) ? 16'sd32767 : (rx < -36'sd32768) ? -16'sd32768 : 16'(rx);
		sz = (rz > 36'sd32767) ? 16'sd32767 : (rz < -36'sd32768) ? -16'sd32768 : 16'(rz);
		ar = (acc_q + AngW'(65536)) >>> 17;
	end

	// Datapath sequencing under controller commands.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q <= 17'(left_speed) - 17'(right_speed);
			sum_q  <= 17'(left_speed) + 17'(right_speed);
			pass_q <= 1'b0;
		end
		if (cmd.rot_end) pass_q <= 1'b1;
		if (cmd.prep) begin
			prod_q <= diff_q * $signed({1'b0, iwb_q});
			x_q    <= VecW'(dir_x_q) <<< 16;
			z_q    <= VecW'(dir_z_q) <<< 16;
		end
		if (cmd.reduce) begin
			mag_q <= pass_q ? (pmag <<< 5) : (pmag <<< 6);
			neg_q <= prod_q < 0;
		end
		if (cmd.quot) quo_q <= quo_prod[29:24];
		// The remainder takes the sign of the angle.
		if (cmd.remainder) ang_q <= neg_q ? -rem : rem;
		if (cmd.fold) begin
			if (red > AngHalfPi) begin
				x_q <= -x_q; z_q <= -z_q; ang_q <= red - AngPi;
			end else if (red < -AngHalfPi) begin
				x_q <= -x_q; z_q <= -z_q; ang_q <= red + AngPi;
			end else begin
				ang_q <= red;
			end
		end
		if (cmd.scale) begin
			x_q <= VecW'(px >>> 30);
			z_q <= VecW'(pz >>> 30);
		end
		if (cmd.iter_clr) it_q <= '0;
		if (cmd.rot_step) begin
			it_q <= it_q + 1'b1;
			if (ang_q >= 0) begin
				x_q <= x_q - sh_z; z_q <= z_q + sh_x; ang_q <= ang_q - tab;
			end else begin
				x_q <= x_q + sh_z; z_q <= z_q - sh_x; ang_q <= ang_q + tab;
			end
		end
		if (cmd.rot_end) begin
			if (pass_q) begin
				mid_x_q <= sx; mid_z_q <= sz;
			end else begin
				new_x_q <= sx; new_z_q <= sz;
			end
		end
		if (cmd.pos_mul) begin
			stepx_q <= (sum_q * mid_x_q + 34'sd64) >>> 7;
			stepz_q <= (sum_q * mid_z_q + 34'sd64) >>> 7;
		end
		if (cmd.at_init) begin
			x_q   <= (dir_x_q < 0) ? -(VecW'(dir_x_q) <<< 16) : (VecW'(dir_x_q) <<< 16);
			z_q   <= (dir_x_q < 0) ? -(VecW'(dir_z_q) <<< 16) : (VecW'(dir_z_q) <<< 16);
			acc_q <= (dir_x_q < 0) ? ((dir_z_q >= 0) ? AngPi : -AngPi) : '0;
		end
		if (cmd.at_step) begin
			it_q <= it_q + 1'b1;
			if (z_q >= 0) begin
				x_q <= x_q + sh_z; z_q <= z_q - sh_x; acc_q <= acc_q + tab;
			end else begin
				x_q <= x_q - sh_z; z_q <= z_q + sh_x; acc_q <= acc_q - tab;
			end
		end
		if (cmd.finish) begin
			if (dir_x_q == 0 && dir_z_q == 0) angle_q <= '0;
			else if (-ar > AngW'(AngClamp)) angle_q <= AngClamp;
			else if (-ar < -AngW'(AngClamp)) angle_q <= -AngClamp;
			else angle_q <= 16'(-ar);
		end
	end

	assign position_x    = pos_x_q;
	assign position_z    = pos_z_q;
	assign heading_x     = dir_x_q;
	assign heading_z     = dir_z_q;
	assign heading_angle = angle_q;

endmodule
`default_nettype wire

FILE: rtl/core/differential_drive_pose_update_core.sv
// Top level of the differential-drive pose update core.
// Usage:
// - Input channel "in" carries left_speed and right_speed (signed Q8.8); one
//   transaction is one odometry tick.
// - Output channel "out" carries the new position (Q16.16), the heading
//   vector (Q2.14) and the heading angle (Q3.13), one transaction per tick.
// - cfg_we/cfg_data write inverse_wheel_base while the core is idle.
// Timing: the core is not pipelined; after the input transaction it runs two
//   rotations, the position update and the arctangent before the result is
//   valid. A new tick is taken only in idle, at the earliest in the cycle the
//   result is taken. The shared CORDIC unit runs the two rotations and the
//   arctangent at one iteration per cycle.
// The result is held in output registers; while it waits, input ready stays
//   low, so a stalled receiver holds the core in idle.
// Reset: position goes to (-70, -60), heading to (0, 1), the wheel base
//   reciprocal to one twentieth; no output transaction is pending.
`default_nettype none
module differential_drive_pose_update_core
	import ddpu_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	ddpu_in_if.sink          in,
	ddpu_out_if.source       out
);

	ddpu_cmd_t cmd;
	ddpu_sts_t sts;

	ddpu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ddpu_dp #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.left_speed    (in.left_speed),
		.right_speed   (in.right_speed),
		.cmd           (cmd),
		.sts           (sts),
		.position_x    (out.position_x),
		.position_z    (out.position_z),
		.heading_x     (out.heading_x),
		.heading_z     (out.heading_z),
		.heading_angle (out.heading_angle)
	);

`ifndef SYNTHESIS
	// A new tick is never taken while a result is blocked at the output.
	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && !out.ready) |-> !in.ready)
		else $error("input accepted while output stalled");
	// Accepting a tick never raises output valid in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in.valid && in.ready) |=> !(out.valid && !$past(out.valid)))
		else $error("result appeared too early");
	// The heading angle stays in its clamp range.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> (out.heading_angle <= AngClamp && out.heading_angle >= -AngClamp))
		else $error("heading angle out of range");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_differential_drive_pose_update_core.sv
// Self-checking bench for the pose update core: wheel speed ticks in, predicted poses checked.
module tb_differential_drive_pose_update_core;
	import ddpu_pkg::*;

	localparam int Iters = 16;
	localparam int TickCycles = 3 * (Iters + 5) + 20;
	localparam longint CycleLimit = 400000;
	localparam logic [63:0] CfgIndexIwb = 64'd0;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] pz;
		logic signed [15:0] hx;
		logic signed [15:0] hz;
		logic signed [15:0] ang;
	} pose_t;

	// Directed rows: speeds, and a typed-in pose where one is obvious.
	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		bit                 typed;
		pose_t              pose;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	longint cycle_count = 0;
	int mismatch_count = 0;
	bit out_pressure_free = 1'b0;
	bit in_pressure_free = 1'b0;

	ddpu_in_if  in_ch();
	ddpu_out_if out_ch();

	differential_drive_pose_update_core #(.CORDIC_ITERATIONS(Iters)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in(in_ch.sink), .out(out_ch.source)
	);

	// Predictor state.
	logic [15:0] iwb_model;
	logic [31:0] pos_x_model;
	logic [31:0] pos_z_model;
	longint dir_x_model;
	longint dir_z_model;
	pose_t expected_poses[$];

	always #5 clk = ~clk;

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("** differential_drive_pose_update_core: FAILED **");
			$finish;
		end
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint atan_step(int i);
		return longint'(atan_entry(5'(i)));
	endfunction

	// Rotates a Q2.14 vector by a Q9.30 angle with the CORDIC.
	task automatic rotate_heading(input longint hx, input longint hz, input longint ang,
			output longint ox, output longint oz);
		longint x, z, dx, dz, a;
		x = hx * 65536;
		z = hz * 65536;
		a = ang % longint'(AngTwoPi);
		if (a > longint'(AngPi)) a -= longint'(AngTwoPi);
		else if (a < -longint'(AngPi)) a += longint'(AngTwoPi);
		if (a > longint'(AngHalfPi)) begin
			x = -x; z = -z; a -= longint'(AngPi);
		end else if (a < -longint'(AngHalfPi)) begin
			x = -x; z = -z; a += longint'(AngPi);
		end
		x = floor_shift(x * longint'(CordicKinv), 30);
		z = floor_shift(z * longint'(CordicKinv), 30);
		for (int i = 0; i < Iters; i++) begin
			dx = floor_shift(z, i);
			dz = floor_shift(x, i);
			if (a >= 0) begin
				x -= dx; z += dz; a -= atan_step(i);
			end else begin
				x += dx; z -= dz; a += atan_step(i);
			end
		end
		ox = clip16(floor_shift(x + 32768, 16));
		oz = clip16(floor_shift(z + 32768, 16));
	endtask

	// Angle of a Q2.14 vector in Q3.30 by CORDIC vectoring.
	function automatic longint heading_atan2(longint hz, longint hx);
		longint x, z, dx, dz, acc;
		x = hx * 65536;
		z = hz * 65536;
		acc = 0;
		if (hx == 0 && hz == 0) return 0;
		if (x < 0) begin
			acc = (z >= 0) ? longint'(AngPi) : -longint'(AngPi);
			x = -x; z = -z;
		end
		for (int i = 0; i < Iters; i++) begin
			dx = floor_shift(z, i);
			dz = floor_shift(x, i);
			if (z >= 0) begin
				x += dx; z -= dz; acc += atan_step(i);
			end else begin
				x -= dx; z += dz; acc -= atan_step(i);
			end
		end
		return acc;
	endfunction

	// Advances the predicted pose by one tick and returns the new pose.
	task automatic advance_pose(input logic signed [15:0] left, input logic signed [15:0] right,
			output pose_t p);
		longint l, r, prod, sum, nx, nz, mx, mz, a;
		l = left;
		r = right;
		prod = (l - r) * longint'(iwb_model);
		sum = l + r;
		rotate_heading(dir_x_model, dir_z_model, prod * 64, nx, nz);
		rotate_heading(dir_x_model, dir_z_model, prod * 32, mx, mz);
		pos_x_model += 32'(floor_shift(sum * mx + 64, 7));
		pos_z_model += 32'(floor_shift(sum * mz + 64, 7));
		dir_x_model = nx;
		dir_z_model = nz;
		a = -floor_shift(heading_atan2(dir_z_model, dir_x_model) + 65536, 17);
		if (a > longint'(AngClamp)) a = longint'(AngClamp);
		if (a < -longint'(AngClamp)) a = -longint'(AngClamp);
		p.px = pos_x_model;
		p.pz = pos_z_model;
		p.hx = 16'(dir_x_model);
		p.hz = 16'(dir_z_model);
		p.ang = 16'(a);
	endtask

	task automatic note_mismatch(input string what, input longint exp_v, input longint act_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %s: expected %0d, got %0d at cycle %0d",
				what, exp_v, act_v, cycle_count);
	endtask

	// Output sink: random stalls, compare each transaction with the oldest pose.
	initial begin
		pose_t e;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_poses.size() == 0) begin
					note_mismatch("unexpected transaction", 0, 1);
				end else begin
					e = expected_poses.pop_front();
					if (out_ch.position_x !== e.px)
						note_mismatch("position_x", e.px, out_ch.position_x);
					if (out_ch.position_z !== e.pz)
						note_mismatch("position_z", e.pz, out_ch.position_z);
					if (out_ch.heading_x !== e.hx)
						note_mismatch("heading_x", e.hx, out_ch.heading_x);
					if (out_ch.heading_z !== e.hz)
						note_mismatch("heading_z", e.hz, out_ch.heading_z);
					if (out_ch.heading_angle !== e.ang)
						note_mismatch("heading_angle", e.ang, out_ch.heading_angle);
				end
			end
			out_ch.ready <= out_pressure_free ? 1'b1 : ($urandom_range(99) >= 24);
		end
	end

	// Sends one tick; the pose is predicted when the transaction is accepted.
	// Valid stays high after acceptance until the next tick or a drain replaces it.
	task automatic send_tick(input logic signed [15:0] left, input logic signed [15:0] right,
			input bit typed, input pose_t typed_pose);
		pose_t p;
		while (!in_pressure_free && $urandom_range(99) < 24) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.left_speed <= left;
		in_ch.right_speed <= right;
		do @(posedge clk); while (!in_ch.ready);
		advance_pose(left, right, p);
		if (typed && p != typed_pose)
			note_mismatch("typed-in pose disagrees with predictor", 0, 1);
		expected_poses.push_back(typed ? typed_pose : p);
	endtask

	// Waits until all poses are back, then lets the core settle.
	task automatic drain;
		in_ch.valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (TickCycles) @(posedge clk);
	endtask

	task automatic write_iwb(input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (CfgIndexIwb == 0) iwb_model = v;
	endtask

	function automatic logic signed [15:0] rand_speed(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(1024)) - 512);
			default: return 16'($signed($urandom_range(64)) - 32);
		endcase
	endfunction

	tick_row_t directed[$];
	pose_t none;

	initial begin
		logic signed [15:0] l, r;
		int mode;
		logic [15:0] settings[4];
		none = '{0, 0, 0, 0, 0};
		in_ch.valid = 1'b0;
		in_ch.left_speed = '0;
		in_ch.right_speed = '0;
		iwb_model = IwbReset;
		pos_x_model = PosXReset;
		pos_z_model = PosZReset;
		dir_x_model = DirXReset;
		dir_z_model = DirZReset;
		// Standing still from reset: pose stays at (-70, -60) heading +z, angle -pi/2.
		directed.push_back('{16'sd0, 16'sd0, 1'b1, '{-32'sd4587520, -32'sd3932160,
			16'sd0, 16'sd16384, -16'sd12868}});
		// Straight ahead by one unit on each wheel.
		directed.push_back('{16'sd256, 16'sd256, 1'b0, none});
		directed.push_back('{16'sd32767, 16'sd32767, 1'b0, none});
		directed.push_back('{-16'sd32768, -16'sd32768, 1'b0, none});
		directed.push_back('{16'sd32767, -16'sd32768, 1'b0, none});
		directed.push_back('{-16'sd32768, 16'sd32767, 1'b0, none});
		directed.push_back('{16'sd1000, -16'sd1000, 1'b0, none});
		directed.push_back('{-16'sd1, 16'sd1, 1'b0, none});
		directed.push_back('{16'sd0, 16'sd32767, 1'b0, none});
		directed.push_back('{-16'sd21845, 16'sd0, 1'b0, none});
		directed.push_back('{16'sd12345, -16'sd555, 1'b0, none});
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_tick(directed[i].left, directed[i].right, directed[i].typed, directed[i].pose);
		drain();

		// Rotations by two whole turns, one each way, exercise the reduction by whole turns.
		write_iwb(16'hFFFF);
		send_tick(16'sd3217, 16'sd0, 1'b0, none);
		send_tick(-16'sd3217, 16'sd0, 1'b0, none);
		send_tick(16'sd0, 16'sd0, 1'b0, none);
		drain();
		// No turning at all: any speeds go straight.
		write_iwb(16'h0000);
		send_tick(16'sd32767, -16'sd32768, 1'b0, none);
		send_tick(-16'sd300, 16'sd900, 1'b0, none);
		drain();

		// Random phases across several wheel base settings.
		settings = '{16'hFFFF, 16'd0, IwbReset, 16'h0000};
		for (int ph = 0; ph < 6; ph++) begin
			write_iwb(ph < 3 ? settings[ph] : 16'($urandom));
			in_pressure_free = (ph == 2);
			out_pressure_free = (ph == 2);
			for (int k = 0; k < 100; k++) begin
				mode = $urandom_range(2);
				l = rand_speed(mode);
				r = ($urandom_range(3) == 0) ? l : rand_speed(mode);
				send_tick(l, r, 1'b0, none);
			end
			drain();
		end
		in_pressure_free = 1'b0;
		out_pressure_free = 1'b0;

		if (mismatch_count == 0) begin
			$display("** differential_drive_pose_update_core: PASSED **");
		end else begin
			$display("** differential_drive_pose_update_core: FAILED **");
		end
		$finish;
	end

endmodule
